/* rtl/ccfr_pkg.sv */
// Package for the COBS/CRC frame receiver.
// Holds result codes, register indexes, inter-module structs and the CRC step.
// No dependencies.
package ccfr_pkg;

  localparam logic [15:0] CrcInit      = 16'hFFFF;
  localparam logic [15:0] CrcPoly      = 16'h1021;
  localparam logic [7:0]  FullCode     = 8'hFF;
  localparam logic [15:0] DefaultMagic = 16'hA15A;
  localparam logic [7:0]  DefaultVer   = 8'h01;
  localparam logic [7:0]  AckRequested = 8'h01;
  localparam logic [4:0]  CountCap     = 5'd18;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_FRAMING   = 3'd1,
    ST_COBS      = 3'd2,
    ST_SHORT     = 3'd3,
    ST_CRC       = 3'd4,
    ST_HDR_SHORT = 3'd5,
    ST_HDR_BAD   = 3'd6
  } status_e;

  typedef enum logic [0:0] {
    CFG_MAGIC   = 1'b0,
    CFG_VERSION = 1'b1
  } cfg_idx_e;

  // one beat leaving the input register
  typedef struct packed {
    logic       adv;
    logic       last;
    logic [7:0] data;
  } step_t;

  // one decoded byte
  typedef struct packed {
    logic       valid;
    logic [7:0] data;
  } emit_t;

  typedef struct packed {
    logic seen;
    logic bad;
  } cobs_st_t;

  typedef struct packed {
    logic [15:0] magic;
    logic [7:0]  version;
    logic [7:0]  mtype;
    logic [31:0] seq;
    logic [7:0]  flags;
    logic [7:0]  src;
    logic [7:0]  dst;
  } hdr_t;

  typedef struct packed {
    logic fill2;
    logic crc_ok;
    logic hdr_full;
  } chk_t;

  // CRC-16/CCITT-FALSE, one byte, MSB first
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/ccfr_if.sv */
// Stream interfaces for the COBS/CRC frame receiver: raw bytes in, results out.
// Depends on nothing.
interface ccfr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_packet;

  modport source (output valid, output rx_byte, output end_of_packet, input ready);
  modport sink   (input valid, input rx_byte, input end_of_packet, output ready);
endinterface

interface ccfr_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [7:0]  msg_kind;
  logic [31:0] seq_number;
  logic [7:0]  source_id;
  logic [7:0]  dest_id;
  logic        ack_request;
  logic [31:0] ack_value;

  modport source (output valid, output status, output msg_kind, output seq_number,
                  output source_id, output dest_id, output ack_request,
                  output ack_value, input ready);
  modport sink   (input valid, input status, input msg_kind, input seq_number,
                  input source_id, input dest_id, input ack_request,
                  input ack_value, output ready);
endinterface

/* rtl/ccfr_cobs_dec.sv */
// COBS decoder: tracks block position, defers the implied zero, flags errors.
// Depends on ccfr_pkg.
module ccfr_cobs_dec (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ccfr_pkg::step_t   step_i,
  output ccfr_pkg::emit_t   emit_o,
  output ccfr_pkg::cobs_st_t st_o
);

  logic [7:0] rem_q, rem_d;
  logic       full_q, full_d;
  logic       zpend_q, zpend_d;
  logic       err_q, err_d;
  logic       seen_q, seen_d;

  always_comb begin
    rem_d   = rem_q;
    full_d  = full_q;
    zpend_d = zpend_q;
    err_d   = err_q;
    seen_d  = seen_q;
    emit_o  = '{valid: 1'b0, data: 8'h00};
    if (step_i.adv) begin
      if (step_i.last) begin
        rem_d   = 8'h00;
        full_d  = 1'b0;
        zpend_d = 1'b0;
        err_d   = 1'b0;
        seen_d  = 1'b0;
      end else begin
        seen_d = 1'b1;
        if (!err_q) begin
          if (rem_q != 8'h00) begin
            emit_o = '{valid: 1'b1, data: step_i.data};
            rem_d  = rem_q - 8'd1;
            if (rem_q == 8'd1) begin
              zpend_d = !full_q;
            end
          end else begin
            // release the deferred zero before the new code byte
            if (zpend_q) begin
              emit_o  = '{valid: 1'b1, data: 8'h00};
              zpend_d = 1'b0;
            end
            if (step_i.data == 8'h00) begin
              err_d = 1'b1;
            end else begin
              rem_d  = step_i.data - 8'd1;
              full_d = (step_i.data == ccfr_pkg::FullCode);
              if (step_i.data == 8'd1) begin
                zpend_d = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  assign st_o.seen = seen_q;
  assign st_o.bad  = err_q || (rem_q != 8'h00);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q   <= 8'h00;
      full_q  <= 1'b0;
      zpend_q <= 1'b0;
      err_q   <= 1'b0;
      seen_q  <= 1'b0;
    end else begin
      rem_q   <= rem_d;
      full_q  <= full_d;
      zpend_q <= zpend_d;
      err_q   <= err_d;
      seen_q  <= seen_d;
    end
  end

endmodule

/* rtl/ccfr_crc_hdr.sv */
// Two-byte delay, running CRC and header capture over decoded bytes.
// Depends on ccfr_pkg.
module ccfr_crc_hdr (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             clear_i,
  input  ccfr_pkg::emit_t  emit_i,
  output ccfr_pkg::hdr_t   hdr_o,
  output ccfr_pkg::chk_t   chk_o
);

  logic [7:0]     dly0_q, dly0_d, dly1_q, dly1_d;
  logic [1:0]     fill_q, fill_d;
  logic [15:0]    crc_q, crc_d;
  logic [4:0]     cnt_q, cnt_d;
  ccfr_pkg::hdr_t hdr_q, hdr_d;
  logic [3:0]     hidx;

  // header index of the byte leaving the delay; only used while cnt_q is 2..17
  assign hidx = cnt_q[3:0] - 4'd2;

  always_comb begin
    dly0_d = dly0_q;
    dly1_d = dly1_q;
    fill_d = fill_q;
    crc_d  = crc_q;
    cnt_d  = cnt_q;
    hdr_d  = hdr_q;
    if (clear_i) begin
      fill_d = 2'd0;
      crc_d  = ccfr_pkg::CrcInit;
      cnt_d  = 5'd0;
    end else if (emit_i.valid) begin
      if (fill_q == 2'd2) begin
        // oldest byte leaves the delay into the CRC
        crc_d = ccfr_pkg::crc16_byte(crc_q, dly0_q);
        if (cnt_q < ccfr_pkg::CountCap) begin
          case (hidx)
            4'd0:    hdr_d.magic[7:0]  = dly0_q;
            4'd1:    hdr_d.magic[15:8] = dly0_q;
            4'd2:    hdr_d.version     = dly0_q;
            4'd3:    hdr_d.mtype       = dly0_q;
            4'd4, 4'd5, 4'd6, 4'd7: hdr_d.seq[8*hidx[1:0] +: 8] = dly0_q;
            4'd12:   hdr_d.flags       = dly0_q;
            4'd13:   hdr_d.src         = dly0_q;
            4'd14:   hdr_d.dst         = dly0_q;
            default: hdr_d = hdr_q;
          endcase
        end
        dly0_d = dly1_q;
        dly1_d = emit_i.data;
      end else begin
        if (fill_q == 2'd0) begin
          dly0_d = emit_i.data;
        end else begin
          dly1_d = emit_i.data;
        end
        fill_d = fill_q + 2'd1;
      end
      if (cnt_q < ccfr_pkg::CountCap) begin
        cnt_d = cnt_q + 5'd1;
      end
    end
  end

  assign hdr_o          = hdr_q;
  assign chk_o.fill2    = (fill_q == 2'd2);
  assign chk_o.crc_ok   = ({dly1_q, dly0_q} == crc_q);
  assign chk_o.hdr_full = (cnt_q == ccfr_pkg::CountCap);

  // payload registers: delay bytes and header fields
  always_ff @(posedge clk_i) begin
    dly0_q <= dly0_d;
    dly1_q <= dly1_d;
    hdr_q  <= hdr_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= 2'd0;
      crc_q  <= ccfr_pkg::CrcInit;
      cnt_q  <= 5'd0;
    end else begin
      fill_q <= fill_d;
      crc_q  <= crc_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

/* rtl/cobs_crc_frame_receiver.sv */
// COBS/CRC frame receiver top level: input register, decoder, CRC/header
// unit, frame checks, sequence tracking and result register.
// Depends on ccfr_pkg, ccfr_in_if, ccfr_out_if, ccfr_cobs_dec, ccfr_crc_hdr.
//
// Usage:
//   rx carries one raw packet byte per beat; end_of_packet marks the last
//   beat, which must be the zero terminator. res carries one result beat per
//   packet: status, header fields, ack_request and ack_value.
//   The config port writes expected magic (index 0) and version (index 1);
//   write it only while no packet is in flight.
// Timing:
//   Every data beat is registered, then decoded into the two-byte delay in
//   the following cycle; one beat per cycle is sustained unless a terminator
//   waits on res. Each result beat is registered in the result register.
//   The rate is set by the per-byte update: COBS step plus one CRC byte step.
// Reset:
//   Clears per-packet control state (not payload), the in-order sequence and
//   restores magic 0xA15A and version 1. No clearing pass is needed.
// Back-pressure:
//   While a result waits on res, data beats keep flowing in; a terminator beat
//   holds in the input register until the result register frees, and rx then
//   stalls behind it.
module cobs_crc_frame_receiver (
  input  logic              clk_i,
  input  logic              rst_ni,
  ccfr_in_if.sink           rx,
  ccfr_out_if.source        res,
  input  logic              cfg_we_i,
  input  logic [0:0]        cfg_idx_i,
  input  logic [15:0]       cfg_data_i
);

  // input register
  logic       s1_valid_q, s1_valid_d;
  logic [7:0] s1_byte_q, s1_byte_d;
  logic       s1_eop_q, s1_eop_d;

  // configuration
  logic [15:0] magic_q;
  logic [7:0]  ver_q;

  // sequence tracking
  logic [31:0] last_q, last_d;

  // result register
  logic                res_valid_q, res_valid_d;
  ccfr_pkg::status_e   st_q, st_d;
  logic [7:0]          mtype_q, mtype_d;
  logic [31:0]         seq_q, seq_d;
  logic [7:0]          src_q, src_d;
  logic [7:0]          dst_q, dst_d;
  logic                ackr_q, ackr_d;
  logic [31:0]         ackv_q, ackv_d;

  logic                out_free;
  logic                s1_adv;
  logic                rx_take;
  ccfr_pkg::step_t     step;
  ccfr_pkg::emit_t     emit;
  ccfr_pkg::cobs_st_t  cobs_st;
  ccfr_pkg::hdr_t      hdr;
  ccfr_pkg::chk_t      chk;
  ccfr_pkg::status_e   status;

  // a terminator needs the result register; data beats never do
  assign out_free = !res_valid_q || res.ready;
  assign s1_adv   = s1_valid_q && (!s1_eop_q || out_free);
  assign rx.ready = !s1_valid_q || s1_adv;
  assign rx_take  = rx.valid && rx.ready;

  assign step = '{adv: s1_adv, last: s1_eop_q, data: s1_byte_q};

  ccfr_cobs_dec u_dec (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .emit_o (emit),
    .st_o   (cobs_st)
  );

  ccfr_crc_hdr u_crc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (s1_adv && s1_eop_q),
    .emit_i  (emit),
    .hdr_o   (hdr),
    .chk_o   (chk)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    s1_byte_d  = s1_byte_q;
    s1_eop_d   = s1_eop_q;
    if (rx_take) begin
      s1_valid_d = 1'b1;
      s1_byte_d  = rx.rx_byte;
      s1_eop_d   = rx.end_of_packet;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
  end

  // frame checks in priority order; first failure wins
  always_comb begin
    if (s1_byte_q != 8'h00 || !cobs_st.seen) begin
      status = ccfr_pkg::ST_FRAMING;
    end else if (cobs_st.bad) begin
      status = ccfr_pkg::ST_COBS;
    end else if (!chk.fill2) begin
      status = ccfr_pkg::ST_SHORT;
    end else if (!chk.crc_ok) begin
      status = ccfr_pkg::ST_CRC;
    end else if (!chk.hdr_full) begin
      status = ccfr_pkg::ST_HDR_SHORT;
    end else if (hdr.magic != magic_q || hdr.version != ver_q) begin
      status = ccfr_pkg::ST_HDR_BAD;
    end else begin
      status = ccfr_pkg::ST_OK;
    end
  end

  always_comb begin
    res_valid_d = res_valid_q;
    st_d        = st_q;
    mtype_d     = mtype_q;
    seq_d       = seq_q;
    src_d       = src_q;
    dst_d       = dst_q;
    ackr_d      = ackr_q;
    ackv_d      = ackv_q;
    last_d      = last_q;
    if (s1_adv && s1_eop_q) begin
      res_valid_d = 1'b1;
      st_d        = status;
      mtype_d     = 8'h00;
      seq_d       = 32'h0;
      src_d       = 8'h00;
      dst_d       = 8'h00;
      ackr_d      = 1'b0;
      ackv_d      = 32'h0;
      if (status == ccfr_pkg::ST_OK) begin
        // advance the in-order mark only on the next sequence number
        if (hdr.seq == last_q + 32'd1) begin
          last_d = hdr.seq;
        end
        mtype_d = hdr.mtype;
        seq_d   = hdr.seq;
        src_d   = hdr.src;
        dst_d   = hdr.dst;
        ackr_d  = |(hdr.flags & ccfr_pkg::AckRequested);
        ackv_d  = last_d;
      end
    end else if (res.ready) begin
      res_valid_d = 1'b0;
    end
  end

  assign res.valid       = res_valid_q;
  assign res.status      = st_q;
  assign res.msg_kind    = mtype_q;
  assign res.seq_number  = seq_q;
  assign res.source_id   = src_q;
  assign res.dest_id     = dst_q;
  assign res.ack_request = ackr_q;
  assign res.ack_value   = ackv_q;

  // payload registers
  always_ff @(posedge clk_i) begin
    s1_byte_q <= s1_byte_d;
    s1_eop_q  <= s1_eop_d;
    st_q      <= st_d;
    mtype_q   <= mtype_d;
    seq_q     <= seq_d;
    src_q     <= src_d;
    dst_q     <= dst_d;
    ackr_q    <= ackr_d;
    ackv_q    <= ackv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      last_q      <= 32'h0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
      last_q      <= last_d;
    end
  end

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      magic_q <= ccfr_pkg::DefaultMagic;
      ver_q   <= ccfr_pkg::DefaultVer;
    end else if (cfg_we_i) begin
      unique case (ccfr_pkg::cfg_idx_e'(cfg_idx_i))
        ccfr_pkg::CFG_MAGIC:   magic_q <= cfg_data_i;
        ccfr_pkg::CFG_VERSION: ver_q   <= cfg_data_i[7:0];
        default:               magic_q <= magic_q;
      endcase
    end
  end

endmodule
